/* rtl/pcc_pkg.sv */
// Shared types, constants and helpers for the palette change classifier.
`timescale 1ns / 1ps

package pcc_pkg;

    localparam int PALETTE_GROUPS = 16;
    localparam int GROUP_SIZE     = 16;

    localparam logic [4:0]  FADE_MIN_LEVEL = 5'd12;
    localparam logic [15:0] COLOR_MASK     = 16'h7fff;
    localparam logic [4:0]  CHANNEL_MASK   = 5'h1f;

    typedef enum logic [1:0] {
        MODE_SKIP,
        MODE_SNAPSHOT,
        MODE_CLASSIFY
    } t_mode;

    typedef enum logic [2:0] {
        VERDICT_UNCHANGED,
        VERDICT_SNAPSHOT,
        VERDICT_CYCLE,
        VERDICT_FLASH,
        VERDICT_FADE,
        VERDICT_OTHER
    } t_verdict;

    typedef enum logic [1:0] {
        CLS_CYCLE,
        CLS_FLASH,
        CLS_FADE,
        CLS_OTHER
    } t_class;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_COMPARE,
        ST_MSET,
        ST_UNIF,
        ST_FIND,
        ST_SCALE,
        ST_UPDATE,
        ST_STORE,
        ST_EMIT
    } t_state;

    // One row of per-group statistics, kept in the stats memory.
    typedef struct packed {
        logic [3:0][31:0] cls_cnt;
        logic [15:0]      max_run;
        logic [15:0]      run_len;
        logic [15:0]      last_chg;
        logic [31:0]      bursts;
        logic [31:0]      chg;
    } t_stats;

    function automatic logic [4:0] chan(input logic [15:0] w, input logic [1:0] c);
        logic [15:0] s;
        s = w >> ({2'b00, c} * 4'd5);
        return s[4:0] & CHANNEL_MASK;
    endfunction

endpackage

/* rtl/palette_change_classifier_unit.sv */
// Palette change classifier: top level with group sequencer and stats update.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+---------------------------------------------
//  in      | i_in_valid | o_in_stall | i_frame_number, i_color_index, i_color_word
//  out     | o_out_valid| i_out_stall| o_group, o_verdict, o_change_count,
//          |            |            | o_verdict_count, o_burst_count,
//          |            |            | o_current_run, o_longest_run
//
// Words that do not close a group are taken while idle. A group close occupies the
// shared palette RAM port: it fetches the stored group and writes it back, and in
// a classify frame it runs up to 16 multiset steps, 16 uniformity steps, 15 search
// steps and 45 scale steps, one per cycle.
// Reset is synchronous and clears control and the stats row valid bits; no
// clearing pass is run. A stalled result holds in the output register while
// the next words are taken; the next group's result waits for it to drain.
`timescale 1ns / 1ps

module palette_change_classifier_unit #(
    parameter int PALETTE_GROUPS = pcc_pkg::PALETTE_GROUPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_frame_number,
    input  logic [7:0]  i_color_index,
    input  logic [15:0] i_color_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_group,
    output logic [2:0]  o_verdict,
    output logic [31:0] o_change_count,
    output logic [31:0] o_verdict_count,
    output logic [31:0] o_burst_count,
    output logic [15:0] o_current_run,
    output logic [15:0] o_longest_run
);

    localparam int GW        = (PALETTE_GROUPS > 1) ? $clog2(PALETTE_GROUPS) : 1;
    localparam int PAL_DEPTH = PALETTE_GROUPS * pcc_pkg::GROUP_SIZE;
    localparam int PAL_AW    = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
    localparam int SW        = $bits(pcc_pkg::t_stats);

    pcc_pkg::t_state   r_state, n_state;
    pcc_pkg::t_mode    r_mode, n_mode;
    pcc_pkg::t_class   r_cls;
    pcc_pkg::t_verdict r_verdict;
    pcc_pkg::t_stats   r_row, n_row, w_stats_rdata;

    logic [15:0] r_snap_frame, n_snap_frame;
    logic        r_snap_valid, n_snap_valid;
    logic [15:0] r_cur  [pcc_pkg::GROUP_SIZE];
    logic [15:0] r_prev [pcc_pkg::GROUP_SIZE];
    logic [3:0]  r_g;
    logic [15:0] r_fn;
    logic [4:0]  r_k;
    logic [1:0]  r_c;
    logic [2:0][4:0] r_lo, r_hi;
    logic [3:0]  r_n;
    logic [4:0]  r_num, r_den;
    logic [PALETTE_GROUPS-1:0] r_row_valid;

    logic        r_out_valid;
    logic [3:0]  r_out_group;
    logic [2:0]  r_out_verdict;
    logic [31:0] r_out_chg, r_out_vcnt, r_out_bursts;
    logic [15:0] r_out_run, r_out_max;

    logic        w_acc, w_live, w_take, w_last, w_tracked, w_start;
    logic [3:0]  w_i;
    logic [15:0] w_pivot, w_umask;
    logic [15:0] w_mc, w_mp;
    logic        w_same, w_equal, w_uniform;
    logic        w_found;
    logic [4:0]  w_fnum, w_fden;
    logic [4:0]  w_p, w_cu;
    logic [9:0]  w_prod;
    logic [10:0] w_lo_b, w_hi_b;
    logic        w_scale_ok;
    logic [15:0] w_pal_rdata;
    logic        w_pal_we, w_stats_we, w_emit;
    logic [SW-1:0] w_stats_raw;

    assign w_i        = r_k[3:0];
    assign o_in_stall = (r_state != pcc_pkg::ST_IDLE);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_tracked  = (32'(i_color_index[7:4]) < PALETTE_GROUPS);
    assign w_last     = (i_color_index[3:0] == 4'hf);

    // Frame start and word filtering.
    always_comb begin
        n_snap_frame = r_snap_frame;
        n_snap_valid = r_snap_valid;
        n_mode       = r_mode;
        if (i_color_index == 8'd0) begin
            w_live = 1'b1;
            if (r_snap_valid && i_frame_number == r_snap_frame) begin
                n_mode = pcc_pkg::MODE_SKIP;
            end else begin
                n_mode = (r_snap_valid && 16'(i_frame_number - r_snap_frame) == 16'd1)
                         ? pcc_pkg::MODE_CLASSIFY : pcc_pkg::MODE_SNAPSHOT;
                n_snap_frame = i_frame_number;
                n_snap_valid = 1'b1;
            end
        end else begin
            w_live = (i_frame_number == r_snap_frame);
        end
        w_take = w_live && w_tracked &&
                 (n_mode == pcc_pkg::MODE_SNAPSHOT || n_mode == pcc_pkg::MODE_CLASSIFY);
    end

    assign w_start = w_acc && w_take && w_last;

    // Group comparisons; all indexed reads go through w_i.
    always_comb begin
        w_pivot = r_cur[w_i];
        w_equal = 1'b1;
        for (int j = 0; j < pcc_pkg::GROUP_SIZE; j++) begin
            w_mc[j] = (r_cur[j] == w_pivot);
            w_mp[j] = (r_prev[j] == w_pivot);
            if (r_cur[j] != r_prev[j]) begin
                w_equal = 1'b0;
            end
        end
        w_same  = ($countones(w_mc) == $countones(w_mp));
        w_umask = w_pivot & pcc_pkg::COLOR_MASK;
        w_uniform = (r_n >= 4'd4) &&
                    (r_hi[0] - r_lo[0] <= 5'd3) &&
                    (r_hi[1] - r_lo[1] <= 5'd3) &&
                    (r_hi[2] - r_lo[2] <= 5'd3);

        w_found = 1'b0;
        w_fnum  = '0;
        w_fden  = '0;
        for (int c = 2; c >= 0; c--) begin
            if (pcc_pkg::chan(r_prev[w_i], 2'(c)) >= pcc_pkg::FADE_MIN_LEVEL) begin
                w_found = 1'b1;
                w_fnum  = pcc_pkg::chan(w_pivot, 2'(c));
                w_fden  = pcc_pkg::chan(r_prev[w_i], 2'(c));
            end
        end

        // floor(p*num/den) within 2 of cu, without dividing.
        w_p        = pcc_pkg::chan(r_prev[w_i], r_c);
        w_cu       = pcc_pkg::chan(w_pivot, r_c);
        w_prod     = 10'(w_p) * 10'(r_num);
        w_lo_b     = (11'(w_cu) - 11'd2) * 11'(r_den);
        w_hi_b     = (11'(w_cu) + 11'd3) * 11'(r_den);
        w_scale_ok = ((w_cu < 5'd2) || (11'(w_prod) >= w_lo_b)) && (11'(w_prod) < w_hi_b);
    end

    // Stats row update for a changed group.
    always_comb begin
        n_row     = r_row;
        n_row.chg = r_row.chg + 32'd1;
        if (16'(r_fn - r_row.last_chg) == 16'd1) begin
            n_row.run_len = r_row.run_len + 16'd1;
        end else begin
            n_row.bursts  = r_row.bursts + 32'd1;
            n_row.run_len = 16'd1;
        end
        if (n_row.run_len > r_row.max_run) begin
            n_row.max_run = n_row.run_len;
        end
        n_row.last_chg       = r_fn;
        n_row.cls_cnt[r_cls] = r_row.cls_cnt[r_cls] + 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_pal_we   = 1'b0;
        w_stats_we = 1'b0;
        w_emit     = 1'b0;
        unique case (r_state)
            pcc_pkg::ST_IDLE: begin
                if (w_start) n_state = pcc_pkg::ST_LOAD;
            end
            pcc_pkg::ST_LOAD: begin
                if (r_k == 5'd16) n_state = pcc_pkg::ST_COMPARE;
            end
            pcc_pkg::ST_COMPARE: begin
                if (r_mode == pcc_pkg::MODE_SNAPSHOT || w_equal) begin
                    n_state = pcc_pkg::ST_STORE;
                end else begin
                    n_state = pcc_pkg::ST_MSET;
                end
            end
            pcc_pkg::ST_MSET: begin
                if (!w_same) n_state = pcc_pkg::ST_UNIF;
                else if (r_k == 5'd15) n_state = pcc_pkg::ST_UPDATE;
            end
            pcc_pkg::ST_UNIF: begin
                if (r_k == 5'd16) begin
                    n_state = w_uniform ? pcc_pkg::ST_UPDATE : pcc_pkg::ST_FIND;
                end
            end
            pcc_pkg::ST_FIND: begin
                if (w_found) n_state = pcc_pkg::ST_SCALE;
                else if (r_k == 5'd15) n_state = pcc_pkg::ST_UPDATE;
            end
            pcc_pkg::ST_SCALE: begin
                if (!w_scale_ok || (r_k == 5'd15 && r_c == 2'd2)) begin
                    n_state = pcc_pkg::ST_UPDATE;
                end
            end
            pcc_pkg::ST_UPDATE: begin
                w_stats_we = 1'b1;
                n_state    = pcc_pkg::ST_STORE;
            end
            pcc_pkg::ST_STORE: begin
                w_pal_we = 1'b1;
                if (r_k == 5'd15) n_state = pcc_pkg::ST_EMIT;
            end
            pcc_pkg::ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_emit  = 1'b1;
                    n_state = pcc_pkg::ST_IDLE;
                end
            end
            default: n_state = pcc_pkg::ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_frame <= '0;
            r_snap_valid <= 1'b0;
            r_mode       <= pcc_pkg::MODE_SKIP;
            r_row_valid  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_acc) begin
                r_snap_frame <= n_snap_frame;
                r_snap_valid <= n_snap_valid;
                r_mode       <= n_mode;
            end
            if (w_stats_we) begin
                r_row_valid[GW'(r_g)] <= 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (w_acc && w_take) begin
            r_cur[i_color_index[3:0]] <= i_color_word;
        end
        unique case (r_state)
            pcc_pkg::ST_IDLE: begin
                r_k  <= '0;
                r_g  <= i_color_index[7:4];
                r_fn <= i_frame_number;
            end
            pcc_pkg::ST_LOAD: begin
                r_k <= r_k + 5'd1;
                if (r_k != 5'd0) begin
                    r_prev[4'(r_k - 5'd1)] <= w_pal_rdata;
                end
                if (r_k == 5'd1) begin
                    r_row <= r_row_valid[GW'(r_g)] ? w_stats_rdata : '0;
                end
            end
            pcc_pkg::ST_COMPARE: begin
                r_k <= '0;
                if (r_mode == pcc_pkg::MODE_SNAPSHOT) begin
                    r_verdict <= pcc_pkg::VERDICT_SNAPSHOT;
                end else if (w_equal) begin
                    r_verdict <= pcc_pkg::VERDICT_UNCHANGED;
                end
            end
            pcc_pkg::ST_MSET: begin
                r_cls <= pcc_pkg::CLS_CYCLE;
                if (!w_same) begin
                    r_k  <= 5'd1;
                    r_lo <= {3{5'd31}};
                    r_hi <= '0;
                    r_n  <= '0;
                end else begin
                    r_k <= r_k + 5'd1;
                end
            end
            pcc_pkg::ST_UNIF: begin
                r_cls <= pcc_pkg::CLS_FLASH;
                if (r_k == 5'd16) begin
                    r_k <= 5'd1;
                end else begin
                    r_k <= r_k + 5'd1;
                    if (w_umask != 16'd0) begin
                        r_n <= r_n + 4'd1;
                        for (int c = 0; c < 3; c++) begin
                            if (pcc_pkg::chan(w_umask, 2'(c)) < r_lo[c]) begin
                                r_lo[c] <= pcc_pkg::chan(w_umask, 2'(c));
                            end
                            if (pcc_pkg::chan(w_umask, 2'(c)) > r_hi[c]) begin
                                r_hi[c] <= pcc_pkg::chan(w_umask, 2'(c));
                            end
                        end
                    end
                end
            end
            pcc_pkg::ST_FIND: begin
                r_cls <= pcc_pkg::CLS_OTHER;
                if (w_found) begin
                    r_num <= w_fnum;
                    r_den <= w_fden;
                    r_k   <= 5'd1;
                    r_c   <= '0;
                end else begin
                    r_k <= r_k + 5'd1;
                end
            end
            pcc_pkg::ST_SCALE: begin
                r_cls <= w_scale_ok ? pcc_pkg::CLS_FADE : pcc_pkg::CLS_OTHER;
                if (r_c == 2'd2) begin
                    r_c <= '0;
                    r_k <= r_k + 5'd1;
                end else begin
                    r_c <= r_c + 2'd1;
                end
            end
            pcc_pkg::ST_UPDATE: begin
                r_k   <= '0;
                r_row <= n_row;
                unique case (r_cls)
                    pcc_pkg::CLS_CYCLE: r_verdict <= pcc_pkg::VERDICT_CYCLE;
                    pcc_pkg::CLS_FLASH: r_verdict <= pcc_pkg::VERDICT_FLASH;
                    pcc_pkg::CLS_FADE:  r_verdict <= pcc_pkg::VERDICT_FADE;
                    pcc_pkg::CLS_OTHER: r_verdict <= pcc_pkg::VERDICT_OTHER;
                    default:            r_verdict <= pcc_pkg::VERDICT_OTHER;
                endcase
            end
            pcc_pkg::ST_STORE: begin
                r_k <= r_k + 5'd1;
            end
            pcc_pkg::ST_EMIT: begin
                if (w_emit) begin
                    r_out_group   <= r_g;
                    r_out_verdict <= r_verdict;
                    r_out_chg     <= r_row.chg;
                    r_out_bursts  <= r_row.bursts;
                    r_out_run     <= r_row.run_len;
                    r_out_max     <= r_row.max_run;
                    r_out_vcnt    <= (r_verdict == pcc_pkg::VERDICT_UNCHANGED ||
                                      r_verdict == pcc_pkg::VERDICT_SNAPSHOT)
                                     ? 32'd0 : r_row.cls_cnt[r_cls];
                end
            end
            default: r_k <= '0;
        endcase
    end

    pcc_ram #(
        .WIDTH (16),
        .DEPTH (PAL_DEPTH)
    ) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (w_pal_we),
        .i_addr  (PAL_AW'({GW'(r_g), w_i})),
        .i_wdata (r_cur[w_i]),
        .o_rdata (w_pal_rdata)
    );

    pcc_ram #(
        .WIDTH (SW),
        .DEPTH (PALETTE_GROUPS)
    ) u_stats_ram (
        .i_clk   (i_clk),
        .i_we    (w_stats_we),
        .i_addr  (GW'(r_g)),
        .i_wdata (n_row),
        .o_rdata (w_stats_raw)
    );

    assign w_stats_rdata = pcc_pkg::t_stats'(w_stats_raw);

    assign o_out_valid     = r_out_valid;
    assign o_group         = r_out_group;
    assign o_verdict       = r_out_verdict;
    assign o_change_count  = r_out_chg;
    assign o_verdict_count = r_out_vcnt;
    assign o_burst_count   = r_out_bursts;
    assign o_current_run   = r_out_run;
    assign o_longest_run   = r_out_max;

endmodule

/* rtl/pcc_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module pcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pcc_checker.sv */
// Port-level assertions for the palette change classifier, with bind.
`timescale 1ns / 1ps

module pcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_verdict,
    input logic [31:0] o_verdict_count,
    input logic [15:0] o_current_run,
    input logic [15:0] o_longest_run
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_verdict <= pcc_pkg::VERDICT_OTHER))
        else $error("verdict out of range");

    a_vcount_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_verdict == pcc_pkg::VERDICT_UNCHANGED ||
                         o_verdict == pcc_pkg::VERDICT_SNAPSHOT))
        |-> (o_verdict_count == 32'd0))
        else $error("verdict count set on unchanged or snapshot result");

    a_run_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_current_run <= o_longest_run))
        else $error("current run exceeds longest run");

endmodule

bind palette_change_classifier_unit pcc_checker u_pcc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_verdict       (o_verdict),
    .o_verdict_count (o_verdict_count),
    .o_current_run   (o_current_run),
    .o_longest_run   (o_longest_run)
);
